@@ design/tsr_pkg.sv @@
// Shared types and constants of the touch stroke rasterizer.
// No dependencies; tsr_if, tsr_front, tsr_queue, tsr_back and the top level use this package.
package tsr_pkg;

  localparam int CMD_W      = 2;
  localparam int COORD_W    = 10;
  localparam int ADDR_W     = 9;
  localparam int BYTE_W     = 8;
  // Grid cells are at most 256 wide or high.
  localparam int CELL_W     = 8;
  localparam int REG_IDX_W  = 2;
  localparam int REG_DATA_W = 10;

  localparam logic [CMD_W-1:0] CMD_TOUCH = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_PAD_ENABLED = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_PAD_LEFT    = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_PAD_TOP     = 2'd2;

  localparam logic [COORD_W-1:0] PAD_LEFT_RST = 10'd89;
  localparam logic [COORD_W-1:0] PAD_TOP_RST  = 10'd70;

  typedef enum logic [1:0] {
    OP_NOP,
    OP_CLEAR,
    OP_READ,
    OP_DRAW
  } op_kind_t;

  // One classified command on its way from the front end to the drawing engine.
  typedef struct packed {
    op_kind_t            kind;
    logic [CELL_W-1:0]   x0;
    logic [CELL_W-1:0]   y0;
    logic [CELL_W-1:0]   x1;
    logic [CELL_W-1:0]   y1;
    logic [ADDR_W-1:0]   addr;
  } op_t;

endpackage

@@ design/tsr_if.sv @@
// Channel interfaces: command requests, results and register writes.
// Depends on tsr_pkg for field widths.
interface tsr_req_if;
  logic                         valid;
  logic                         ready;
  logic [tsr_pkg::CMD_W-1:0]    cmd;
  logic                         pressed;
  logic [tsr_pkg::COORD_W-1:0]  touch_x;
  logic [tsr_pkg::COORD_W-1:0]  touch_y;
  logic [tsr_pkg::ADDR_W-1:0]   byte_addr;

  modport source (output valid, cmd, pressed, touch_x, touch_y, byte_addr, input ready);
  modport sink   (input valid, cmd, pressed, touch_x, touch_y, byte_addr, output ready);
endinterface

interface tsr_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [tsr_pkg::BYTE_W-1:0]   read_byte;
  logic                         drew;
  logic                         ink_present;

  modport source (output valid, read_byte, drew, ink_present, input ready);
  modport sink   (input valid, read_byte, drew, ink_present, output ready);
endinterface

interface tsr_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [tsr_pkg::REG_IDX_W-1:0]    index;
  logic [tsr_pkg::REG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ design/touch_stroke_rasterizer.sv @@
// Channel   Role    Payload
// req       sink    cmd, pressed, touch_x, touch_y, byte_addr
// rsp       source  read_byte, drew, ink_present (one item per request)
// cfg       sink    index, data (always ready)
//
// Touch inside the pad: reciprocal scaling (F_DIV), then a push of the op (F_PUSH),
//   then a read and a write back of the bitmap byte on the RAM port for each plotted pixel.
// The clearing pass after reset zeroes every bitmap byte before any item runs.
// A two-entry op queue lets new requests enter while the engine draws or a result waits.
//
// Top level: front end, op queue and drawing engine. Depends on tsr_pkg and tsr_if.
module touch_stroke_rasterizer #(
  parameter int GRID_W   = 64,
  parameter int GRID_H   = 64,
  parameter int PAD_SPAN = 288
) (
  input  logic       clk,
  input  logic       rst,
  tsr_req_if.sink    req,
  tsr_rsp_if.source  rsp,
  tsr_cfg_if.sink    cfg
);
  import tsr_pkg::*;

  op_t  push_op;
  op_t  head_op;
  logic push;
  logic full;
  logic pop;
  logic head_valid;

  tsr_front #(.GRID_W(GRID_W), .GRID_H(GRID_H), .PAD_SPAN(PAD_SPAN)) u_front (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .cfg     (cfg),
    .op      (push_op),
    .op_push (push),
    .op_full (full)
  );

  tsr_queue #(.DEPTH(2)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (push_op),
    .full  (full),
    .pop   (pop),
    .dout  (head_op),
    .valid (head_valid)
  );

  tsr_back #(.GRID_W(GRID_W), .GRID_H(GRID_H)) u_back (
    .clk      (clk),
    .rst      (rst),
    .op       (head_op),
    .op_valid (head_valid),
    .op_pop   (pop),
    .rsp      (rsp)
  );

endmodule

@@ design/tsr_front.sv @@
// Front end: pad registers, touch classification, scaling to grid cells.
// Depends on tsr_pkg and tsr_if; feeds classified ops into the queue.
module tsr_front #(
  parameter int GRID_W   = 64,
  parameter int GRID_H   = 64,
  parameter int PAD_SPAN = 288
) (
  input  logic           clk,
  input  logic           rst,
  tsr_req_if.sink        req,
  tsr_cfg_if.sink        cfg,
  output tsr_pkg::op_t   op,
  output logic           op_push,
  input  logic           op_full
);
  import tsr_pkg::*;

  localparam int GMAX  = (GRID_W > GRID_H) ? GRID_W : GRID_H;
  localparam int QW    = $clog2(GMAX);
  localparam int PRODW = COORD_W + $clog2(GMAX + 1);
  localparam int SUMW  = COORD_W + 1;
  // Reciprocal of the pad span, exact for every product below 2**PRODW.
  localparam int SPANW = $clog2(PAD_SPAN);
  localparam int SHIFT = PRODW + SPANW;
  localparam int MW    = PRODW + 2;
  localparam int MULW  = PRODW + MW;
  localparam logic [MW-1:0] RECIP =
    MW'(((64'd1 << SHIFT) + 64'(PAD_SPAN) - 64'd1) / 64'(PAD_SPAN));

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_DIV  = 3'b010,
    F_PUSH = 3'b100
  } fstate_t;

  fstate_t             state;
  logic                pad_enabled;
  logic [COORD_W-1:0]  pad_left;
  logic [COORD_W-1:0]  pad_top;
  logic                was_pressed;
  logic [CELL_W-1:0]   last_x;
  logic [CELL_W-1:0]   last_y;
  logic [PRODW-1:0]    prod_x;
  logic [PRODW-1:0]    prod_y;
  logic [QW-1:0]       qx;
  logic [QW-1:0]       qy;

  logic                accept;
  logic                in_pad;
  logic                need_div;
  logic [COORD_W-1:0]  ox;
  logic [COORD_W-1:0]  oy;
  logic [CELL_W-1:0]   px;
  logic [CELL_W-1:0]   py;
  logic [MULW-1:0]     mul_x;
  logic [MULW-1:0]     mul_y;

  assign cfg.ready = 1'b1;
  assign req.ready = (state == F_IDLE) && !op_full;
  assign accept    = req.valid && req.ready;

  assign in_pad = (req.touch_x >= pad_left) &&
                  (SUMW'(req.touch_x) < SUMW'(pad_left) + SUMW'(PAD_SPAN)) &&
                  (req.touch_y >= pad_top) &&
                  (SUMW'(req.touch_y) < SUMW'(pad_top) + SUMW'(PAD_SPAN));
  assign need_div = (req.cmd == CMD_TOUCH) && pad_enabled && req.pressed && in_pad;
  assign ox = req.touch_x - pad_left;
  assign oy = req.touch_y - pad_top;

  assign mul_x = MULW'(prod_x) * MULW'(RECIP);
  assign mul_y = MULW'(prod_y) * MULW'(RECIP);

  // Quotient stays below the grid size; clamp only as a guard.
  assign px = ({1'b0, qx} >= (QW+1)'(GRID_W)) ? CELL_W'(GRID_W - 1) : CELL_W'(qx);
  assign py = ({1'b0, qy} >= (QW+1)'(GRID_H)) ? CELL_W'(GRID_H - 1) : CELL_W'(qy);

  always_comb begin
    op      = '0;
    op.kind = OP_NOP;
    op_push = 1'b0;
    if (state == F_PUSH) begin
      op.kind = OP_DRAW;
      op.x0   = was_pressed ? last_x : px;
      op.y0   = was_pressed ? last_y : py;
      op.x1   = px;
      op.y1   = py;
      op_push = !op_full;
    end else begin
      case (req.cmd)
        CMD_CLEAR: op.kind = OP_CLEAR;
        CMD_READ: begin
          op.kind = OP_READ;
          op.addr = req.byte_addr;
        end
        default: op.kind = OP_NOP;
      endcase
      op_push = accept && !need_div;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pad_enabled <= 1'b0;
      pad_left    <= PAD_LEFT_RST;
      pad_top     <= PAD_TOP_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_PAD_ENABLED: pad_enabled <= cfg.data[0];
        REG_PAD_LEFT:    pad_left    <= cfg.data;
        REG_PAD_TOP:     pad_top     <= cfg.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= F_IDLE;
      was_pressed <= 1'b0;
      last_x      <= '0;
      last_y      <= '0;
    end else begin
      case (state)
        F_IDLE: begin
          if (accept && (req.cmd == CMD_TOUCH) && pad_enabled) begin
            if (need_div) begin
              state <= F_DIV;
            end else begin
              was_pressed <= req.pressed;
            end
          end
        end
        F_DIV: begin
          state <= F_PUSH;
        end
        F_PUSH: begin
          if (!op_full) begin
            last_x      <= px;
            last_y      <= py;
            was_pressed <= 1'b1;
            state       <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  // Scale by the grid size, then divide by the pad span through its reciprocal.
  always_ff @(posedge clk) begin
    if (state == F_IDLE) begin
      prod_x <= PRODW'(ox) * PRODW'(GRID_W);
      prod_y <= PRODW'(oy) * PRODW'(GRID_H);
    end else if (state == F_DIV) begin
      qx <= QW'(mul_x >> SHIFT);
      qy <= QW'(mul_y >> SHIFT);
    end
  end

endmodule

@@ design/tsr_queue.sv @@
// Short op queue between the front end and the drawing engine.
// Depends on tsr_pkg for the op type.
module tsr_queue #(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  tsr_pkg::op_t   din,
  output logic           full,
  input  logic           pop,
  output tsr_pkg::op_t   dout,
  output logic           valid
);
  import tsr_pkg::*;

  localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  op_t             slots [DEPTH];
  logic [PTRW-1:0] wr_ptr;
  logic [PTRW-1:0] rd_ptr;
  logic [CNTW-1:0] count;

  assign full  = (count == CNTW'(DEPTH));
  assign valid = (count != '0);
  assign dout  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTRW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PTRW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

@@ design/tsr_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module tsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

@@ design/tsr_back.sv @@
// Drawing engine: bitmap clear sweeps, byte reads and Bresenham line plotting.
// Depends on tsr_pkg, tsr_if and tsr_ram; drives the result channel.
module tsr_back #(
  parameter int GRID_W = 64,
  parameter int GRID_H = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  tsr_pkg::op_t   op,
  input  logic           op_valid,
  output logic           op_pop,
  tsr_rsp_if.source      rsp
);
  import tsr_pkg::*;

  localparam int BYTES = (GRID_W * GRID_H + 7) / 8;
  localparam int AW    = $clog2(BYTES);
  localparam int PIXW  = $clog2(GRID_W * GRID_H);
  localparam int EW    = CELL_W + 3;

  typedef enum logic [4:0] {
    B_CLEAR   = 5'b00001,
    B_IDLE    = 5'b00010,
    B_READ    = 5'b00100,
    B_PLOT_RD = 5'b01000,
    B_PLOT_WR = 5'b10000
  } bstate_t;

  bstate_t               state;
  logic [AW-1:0]         clr_cnt;
  logic                  clr_report;
  logic                  ink;
  logic                  rd_ok;
  logic [CELL_W-1:0]     cx;
  logic [CELL_W-1:0]     cy;
  logic [CELL_W-1:0]     ex;
  logic [CELL_W-1:0]     ey;
  logic                  sx;
  logic                  sy;
  logic signed [EW-1:0]  dx;
  logic signed [EW-1:0]  dy;
  logic signed [EW-1:0]  err;
  logic [AW-1:0]         wbyte;
  logic [2:0]            bsel;
  logic                  res_valid;
  logic [BYTE_W-1:0]     res_byte;
  logic                  res_drew;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [BYTE_W-1:0]     ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [BYTE_W-1:0]     ram_rdata;

  logic [PIXW-1:0]       pix;
  logic [CELL_W-1:0]     adx;
  logic [CELL_W-1:0]     ady;
  logic signed [EW-1:0]  dx_n;
  logic signed [EW-1:0]  dy_n;
  logic signed [EW:0]    e2;
  logic signed [EW:0]    dx_w;
  logic signed [EW:0]    dy_w;
  logic                  step_x;
  logic                  step_y;
  logic                  at_end;

  tsr_ram #(.WIDTH(BYTE_W), .DEPTH(BYTES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rsp.valid       = res_valid;
  assign rsp.read_byte   = res_byte;
  assign rsp.drew        = res_drew;
  assign rsp.ink_present = ink;

  assign op_pop = (state == B_IDLE) && op_valid && !res_valid;

  assign pix  = PIXW'(PIXW'(cy) * PIXW'(GRID_W) + PIXW'(cx));
  assign adx  = (op.x1 > op.x0) ? op.x1 - op.x0 : op.x0 - op.x1;
  assign ady  = (op.y1 > op.y0) ? op.y1 - op.y0 : op.y0 - op.y1;
  assign dx_n = $signed({3'b000, adx});
  assign dy_n = -$signed({3'b000, ady});

  assign e2     = {err, 1'b0};
  assign dx_w   = {dx[EW-1], dx};
  assign dy_w   = {dy[EW-1], dy};
  assign step_x = (e2 >= dy_w);
  assign step_y = (e2 <= dx_w);
  assign at_end = (cx == ex) && (cy == ey);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wbyte;
    ram_wdata = ram_rdata | (BYTE_W'(1) << bsel);
    ram_raddr = AW'(op.addr);
    case (state)
      B_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt;
        ram_wdata = '0;
      end
      B_PLOT_RD: ram_raddr = AW'(pix >> 3);
      B_PLOT_WR: ram_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_CLEAR;
      clr_cnt    <= '0;
      clr_report <= 1'b0;
      ink        <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      if (res_valid && rsp.ready) res_valid <= 1'b0;
      case (state)
        B_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == AW'(BYTES - 1)) begin
            state      <= B_IDLE;
            clr_report <= 1'b0;
            if (clr_report) begin
              res_valid <= 1'b1;
              res_byte  <= '0;
              res_drew  <= 1'b0;
            end
          end
        end
        B_IDLE: begin
          if (op_pop) begin
            case (op.kind)
              OP_CLEAR: begin
                ink        <= 1'b0;
                clr_cnt    <= '0;
                clr_report <= 1'b1;
                state      <= B_CLEAR;
              end
              OP_READ: begin
                rd_ok <= (32'(op.addr) < BYTES);
                state <= B_READ;
              end
              OP_DRAW: begin
                cx    <= op.x0;
                cy    <= op.y0;
                ex    <= op.x1;
                ey    <= op.y1;
                sx    <= (op.x0 < op.x1);
                sy    <= (op.y0 < op.y1);
                dx    <= dx_n;
                dy    <= dy_n;
                err   <= dx_n + dy_n;
                ink   <= 1'b1;
                state <= B_PLOT_RD;
              end
              default: begin
                res_valid <= 1'b1;
                res_byte  <= '0;
                res_drew  <= 1'b0;
              end
            endcase
          end
        end
        B_READ: begin
          res_valid <= 1'b1;
          res_byte  <= rd_ok ? ram_rdata : '0;
          res_drew  <= 1'b0;
          state     <= B_IDLE;
        end
        B_PLOT_RD: begin
          wbyte <= AW'(pix >> 3);
          bsel  <= pix[2:0];
          state <= B_PLOT_WR;
        end
        B_PLOT_WR: begin
          if (at_end) begin
            res_valid <= 1'b1;
            res_byte  <= '0;
            res_drew  <= 1'b1;
            state     <= B_IDLE;
          end else begin
            // advance along the major and minor axes as the error term says
            err <= err + (step_x ? dy : EW'(0)) + (step_y ? dx : EW'(0));
            if (step_x) cx <= sx ? cx + 1'b1 : cx - 1'b1;
            if (step_y) cy <= sy ? cy + 1'b1 : cy - 1'b1;
            state <= B_PLOT_RD;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

@@ design/tsr_checker.sv @@
// Port-level checks for touch_stroke_rasterizer, attached with a bind.
// No package dependency; watches the request and result channels.
module tsr_checker (
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [7:0] rsp_read_byte,
  input logic       rsp_drew,
  input logic       rsp_ink_present
);

  logic [3:0] pending;
  logic       req_acc;
  logic       rsp_acc;

  assign req_acc = req_valid && req_ready;
  assign rsp_acc = rsp_valid && rsp_ready;

  // count items taken in but not yet answered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + {3'b000, req_acc} - {3'b000, rsp_acc};
    end
  end

  assert property (@(posedge clk) disable iff (rst) rsp_valid |-> pending != 4'd0)
    else $error("result shown with no request outstanding");

  assert property (@(posedge clk) disable iff (rst) pending <= 4'd5)
    else $error("more requests in flight than the pipeline can hold");

  assert property (@(posedge clk) disable iff (rst) rsp_valid && rsp_drew |-> rsp_ink_present)
    else $error("drawing result without ink");

  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_byte) && $stable(rsp_drew))
    else $error("stalled result changed");

endmodule

bind touch_stroke_rasterizer tsr_checker u_tsr_checker (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_read_byte   (rsp.read_byte),
  .rsp_drew        (rsp.drew),
  .rsp_ink_present (rsp.ink_present)
);

@@ test/testbench.sv @@
// Self-checking bench for touch_stroke_rasterizer: directed strokes, then random phases.
// Uses tsr_pkg and the channel interfaces in tsr_if; predicts every reply in a scoreboard.
module testbench;
  import tsr_pkg::*;

  localparam int GRID_W       = 64;
  localparam int GRID_H       = 64;
  localparam int PAD_SPAN     = 288;
  localparam int BITMAP_BYTES = (GRID_W * GRID_H + 7) / 8;
  localparam int COORD_MAX    = (1 << COORD_W) - 1;
  localparam int SETTLE       = 16;
  localparam int PHASE_ITEMS  = 64;
  localparam int PHASES       = 7;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic               pressed;
    logic [COORD_W-1:0] touch_x;
    logic [COORD_W-1:0] touch_y;
    logic [ADDR_W-1:0]  byte_addr;
  } touch_req_t;

  typedef struct packed {
    logic [BYTE_W-1:0] read_byte;
    logic              drew;
    logic              ink_present;
  } glyph_reply_t;

  class glyph_tracker;
    bit [7:0] glyph [BITMAP_BYTES];
    int last_x, last_y;
    bit was_pressed, ink;
    bit pad_enabled;
    int pad_left, pad_top;
    glyph_reply_t pending_replies[$];
    int errors, requests_seen, replies_seen, touches_drawn;

    function new();
      foreach (glyph[i]) glyph[i] = '0;
      last_x = 0;
      last_y = 0;
      was_pressed = 0;
      ink = 0;
      pad_enabled = 0;
      pad_left = int'(PAD_LEFT_RST);
      pad_top = int'(PAD_TOP_RST);
    endfunction

    function void write_register(logic [REG_IDX_W-1:0] idx, logic [REG_DATA_W-1:0] data);
      case (idx)
        REG_PAD_ENABLED: pad_enabled = data[0];
        REG_PAD_LEFT: pad_left = int'(data);
        REG_PAD_TOP: pad_top = int'(data);
        default: ;
      endcase
    endfunction

    function void plot_cell(int x, int y);
      int pix;
      if (x < 0 || x >= GRID_W || y < 0 || y >= GRID_H) return;
      pix = y * GRID_W + x;
      if ((pix >> 3) >= BITMAP_BYTES) return;
      glyph[pix >> 3][pix & 7] = 1'b1;
      ink = 1'b1;
    endfunction

    function void draw_segment(int x0, int y0, int x1, int y1);
      int dx, dy, sx, sy, err, e2;
      dx = x1 > x0 ? x1 - x0 : x0 - x1;
      sx = x0 < x1 ? 1 : -1;
      dy = -(y1 > y0 ? y1 - y0 : y0 - y1);
      sy = y0 < y1 ? 1 : -1;
      err = dx + dy;
      forever begin
        plot_cell(x0, y0);
        if (x0 == x1 && y0 == y1) break;
        e2 = 2 * err;
        if (e2 >= dy) begin
          err += dy;
          x0 += sx;
        end
        if (e2 <= dx) begin
          err += dx;
          y0 += sy;
        end
      end
    endfunction

    function void note_request(touch_req_t r);
      glyph_reply_t e;
      int tx, ty, cx, cy;
      e = '0;
      tx = int'(r.touch_x);
      ty = int'(r.touch_y);
      requests_seen++;
      if (r.cmd == CMD_TOUCH) begin
        if (pad_enabled) begin
          // Pad bounds in plain int, so a pad past the panel edge does not wrap.
          if (r.pressed && tx >= pad_left && tx < pad_left + PAD_SPAN &&
              ty >= pad_top && ty < pad_top + PAD_SPAN) begin
            cx = (tx - pad_left) * GRID_W / PAD_SPAN;
            cy = (ty - pad_top) * GRID_H / PAD_SPAN;
            if (cx >= GRID_W) cx = GRID_W - 1;
            if (cy >= GRID_H) cy = GRID_H - 1;
            if (was_pressed) draw_segment(last_x, last_y, cx, cy);
            else plot_cell(cx, cy);
            last_x = cx;
            last_y = cy;
            e.drew = 1'b1;
            touches_drawn++;
          end
          was_pressed = r.pressed;
        end
      end else if (r.cmd == CMD_CLEAR) begin
        foreach (glyph[i]) glyph[i] = '0;
        ink = 1'b0;
      end else if (r.cmd == CMD_READ) begin
        if (r.byte_addr < BITMAP_BYTES) e.read_byte = glyph[r.byte_addr];
      end
      e.ink_present = ink;
      pending_replies.push_back(e);
    endfunction

    task report_mismatch(string what);
      errors++;
      if (errors <= 40) $display("%0t mismatch: %s", $time, what);
    endtask

    task check_reply(glyph_reply_t got);
      glyph_reply_t want;
      replies_seen++;
      if (pending_replies.size() == 0) begin
        report_mismatch("reply with no request waiting");
        return;
      end
      want = pending_replies.pop_front();
      if (got.read_byte !== want.read_byte)
        report_mismatch($sformatf("read_byte %h, want %h", got.read_byte, want.read_byte));
      if (got.drew !== want.drew)
        report_mismatch($sformatf("drew %b, want %b", got.drew, want.drew));
      if (got.ink_present !== want.ink_present)
        report_mismatch($sformatf("ink_present %b, want %b", got.ink_present,
                                  want.ink_present));
    endtask
  endclass

  logic clk;
  logic rst;
  bit quiet_tail;
  int cur_x, cur_y;
  glyph_tracker tracker;

  tsr_req_if req();
  tsr_rsp_if rsp();
  tsr_cfg_if cfg();

  touch_stroke_rasterizer #(
    .GRID_W(GRID_W),
    .GRID_H(GRID_H),
    .PAD_SPAN(PAD_SPAN)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp),
    .cfg(cfg)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg.valid && cfg.ready) tracker.write_register(cfg.index, cfg.data);
      if (req.valid && req.ready)
        tracker.note_request({req.cmd, req.pressed, req.touch_x, req.touch_y, req.byte_addr});
      if (rsp.valid && rsp.ready)
        tracker.check_reply({rsp.read_byte, rsp.drew, rsp.ink_present});
    end
  end

  // Reply side: stall in bursts, never in the quiet tail.
  initial begin
    int hold;
    hold = 0;
    rsp.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (quiet_tail) begin
        rsp.ready <= 1'b1;
      end else if (hold > 0) begin
        hold--;
        rsp.ready <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
        hold = $urandom_range(1, 9) - 1;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  initial begin
    #20000000;
    $display("testbench: errors");
    $finish;
  end

  function automatic touch_req_t make_req(logic [CMD_W-1:0] cmd, bit pressed, int x, int y,
                                          int addr);
    touch_req_t r;
    r.cmd = cmd;
    r.pressed = pressed;
    r.touch_x = COORD_W'(x);
    r.touch_y = COORD_W'(y);
    r.byte_addr = ADDR_W'(addr);
    return r;
  endfunction

  function automatic int clamp(int v, int lo, int hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // Mostly strokes inside the pad, with reads near the pen, clears and noise.
  function automatic touch_req_t next_random_item();
    touch_req_t r;
    int roll, lo_x, hi_x, lo_y, hi_y, pix;
    r = $urandom;
    roll = $urandom_range(0, 99);
    lo_x = tracker.pad_left;
    lo_y = tracker.pad_top;
    hi_x = clamp(lo_x + PAD_SPAN - 1, 0, COORD_MAX);
    hi_y = clamp(lo_y + PAD_SPAN - 1, 0, COORD_MAX);
    if (roll < 8) begin
      return r;
    end else if (roll < 13) begin
      r.cmd = CMD_READ;
    end else if (roll < 25) begin
      r.cmd = CMD_READ;
      pix = tracker.last_y * GRID_W + tracker.last_x;
      r.byte_addr = ADDR_W'((pix >> 3) + int'($urandom_range(0, 2)) - 1);
    end else if (roll < 27) begin
      r.cmd = CMD_CLEAR;
    end else if (roll < 29) begin
      r.cmd = CMD_UNUSED;
    end else if (roll < 36) begin
      r.cmd = CMD_TOUCH;
      r.pressed = 1'b0;
    end else if (roll < 41) begin
      r.cmd = CMD_TOUCH;
      r.pressed = 1'b1;
    end else begin
      r.cmd = CMD_TOUCH;
      r.pressed = 1'b1;
      if ($urandom_range(0, 9) < 6) begin
        cur_x = clamp(cur_x + int'($urandom_range(0, 48)) - 24, lo_x, hi_x);
        cur_y = clamp(cur_y + int'($urandom_range(0, 48)) - 24, lo_y, hi_y);
      end else begin
        cur_x = $urandom_range(lo_x, hi_x);
        cur_y = $urandom_range(lo_y, hi_y);
      end
      r.touch_x = COORD_W'(cur_x);
      r.touch_y = COORD_W'(cur_y);
    end
    return r;
  endfunction

  task automatic issue(touch_req_t r);
    if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.cmd <= r.cmd;
    req.pressed <= r.pressed;
    req.touch_x <= r.touch_x;
    req.touch_y <= r.touch_y;
    req.byte_addr <= r.byte_addr;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
  endtask

  // Hold off until every reply is back, then let the engine settle.
  task automatic wait_drained();
    req.valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending_replies.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, int data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= REG_DATA_W'(data);
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_pad(bit en, int left, int top);
    write_reg(REG_PAD_ENABLED, int'(en));
    write_reg(REG_PAD_LEFT, left);
    write_reg(REG_PAD_TOP, top);
  endtask

  initial begin
    int phase, k;
    tracker = new();
    quiet_tail = 1'b0;
    cur_x = 0;
    cur_y = 0;
    rst = 1'b1;
    req.valid = 1'b0;
    req.cmd = CMD_TOUCH;
    req.pressed = 1'b0;
    req.touch_x = '0;
    req.touch_y = '0;
    req.byte_addr = '0;
    cfg.valid = 1'b0;
    cfg.index = REG_PAD_ENABLED;
    cfg.data = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Pad still disabled after reset.
    issue(make_req(CMD_READ, 0, 0, 0, 0));
    issue(make_req(CMD_READ, 1, COORD_MAX, COORD_MAX, BITMAP_BYTES - 1));
    issue(make_req(CMD_TOUCH, 1, 100, 100, 0));
    issue(make_req(CMD_UNUSED, 1, COORD_MAX, COORD_MAX, BITMAP_BYTES - 1));
    wait_drained();
    write_reg(REG_PAD_ENABLED, 1);
    // Corners of the default pad, a release, a press outside, then lines from the last cell.
    issue(make_req(CMD_TOUCH, 1, 89, 70, 0));
    issue(make_req(CMD_TOUCH, 1, 89 + PAD_SPAN - 1, 70 + PAD_SPAN - 1, 0));
    issue(make_req(CMD_TOUCH, 0, 89 + PAD_SPAN - 1, 70 + PAD_SPAN - 1, 0));
    issue(make_req(CMD_TOUCH, 1, 0, 0, 0));
    issue(make_req(CMD_TOUCH, 1, 89 + PAD_SPAN - 1, 70, 0));
    issue(make_req(CMD_TOUCH, 1, 88, 69, 0));
    issue(make_req(CMD_TOUCH, 1, 89 + PAD_SPAN, 70 + PAD_SPAN, 0));
    issue(make_req(CMD_TOUCH, 1, 89, 70 + PAD_SPAN - 1, 0));
    issue(make_req(CMD_READ, 0, 0, 0, 0));
    issue(make_req(CMD_READ, 0, 0, 0, 7));
    issue(make_req(CMD_READ, 0, 0, 0, BITMAP_BYTES - 1));
    issue(make_req(CMD_CLEAR, 1, COORD_MAX, COORD_MAX, BITMAP_BYTES - 1));
    issue(make_req(CMD_READ, 0, 0, 0, BITMAP_BYTES - 8));
    wait_drained();
    // Pad hanging past the panel edge; the stroke continues across the clear.
    write_reg(REG_PAD_LEFT, COORD_MAX);
    write_reg(REG_PAD_TOP, COORD_MAX);
    issue(make_req(CMD_TOUCH, 1, COORD_MAX, COORD_MAX, 0));
    issue(make_req(CMD_TOUCH, 1, COORD_MAX - 1, COORD_MAX, 0));
    wait_drained();
    set_pad(0, 0, 0);
    issue(make_req(CMD_TOUCH, 1, PAD_SPAN - 1, PAD_SPAN - 1, 0));
    issue(make_req(CMD_TOUCH, 0, 0, 0, 0));
    issue(make_req(CMD_CLEAR, 0, 0, 0, 0));
    wait_drained();
    write_reg(REG_PAD_ENABLED, 1);
    issue(make_req(CMD_TOUCH, 1, PAD_SPAN - 1, 0, 0));
    issue(make_req(CMD_READ, 0, 0, 0, 7));

    for (phase = 0; phase < PHASES; phase++) begin
      wait_drained();
      case (phase)
        0: set_pad(1, int'(PAD_LEFT_RST), int'(PAD_TOP_RST));
        1: set_pad(1, 0, 0);
        2: set_pad(1, COORD_MAX - PAD_SPAN + 1, COORD_MAX - PAD_SPAN + 1);
        3: set_pad(1, 900, 40);
        4: set_pad($urandom_range(0, 4) != 0, $urandom_range(0, COORD_MAX),
                   $urandom_range(0, COORD_MAX));
        5: set_pad(0, $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
        default: set_pad(1, $urandom_range(0, 736), $urandom_range(0, 736));
      endcase
      quiet_tail = (phase == PHASES - 1);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        if (phase == 2 && k == PHASE_ITEMS / 2) wait_drained();
        issue(next_random_item());
      end
    end
    wait_drained();

    $display("covered %0d requests over %0d pad settings, %0d replies checked",
             tracker.requests_seen, PHASES + 4, tracker.replies_seen);
    $display("%0d touch samples drew ink", tracker.touches_drawn);
    if (tracker.errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
